>>> rtl/core/window_stack_hit_test_defines.svh
// ----------------------------------------------------------------------------
// Window stack hit test: assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef WINDOW_STACK_HIT_TEST_DEFINES_SVH
`define WINDOW_STACK_HIT_TEST_DEFINES_SVH

// same-cycle implication, quiet during reset
`define WSHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define WSHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, live through reset
`define WSHT_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/wsht_pkg.sv
// ----------------------------------------------------------------------------
// Window stack hit test package
// Shared constants, codes and control types.
// ----------------------------------------------------------------------------
package wsht_pkg;

   localparam int DEF_MAX_WINDOWS = 16;
   localparam int DEF_COORD_BITS  = 12;
   localparam int NUMBER_BITS     = 5;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_CLICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SELECT,
      ST_MOVE
   } state_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic select;
      logic move;
   } ctrl_type;

endpackage

>>> rtl/core/wsht_channels.sv
// ----------------------------------------------------------------------------
// Window stack hit test channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
interface wsht_req_if #(
   parameter int COORD_BITS = wsht_pkg::DEF_COORD_BITS
);
   logic                  valid;
   logic                  ready;
   logic                  mode;
   logic [COORD_BITS-1:0] corner_x_a;
   logic [COORD_BITS-1:0] corner_y_a;
   logic [COORD_BITS-1:0] corner_x_b;
   logic [COORD_BITS-1:0] corner_y_b;

   modport source (output valid, mode, corner_x_a, corner_y_a, corner_x_b, corner_y_b,
                   input ready);
   modport sink (input valid, mode, corner_x_a, corner_y_a, corner_x_b, corner_y_b,
                 output ready);
endinterface

interface wsht_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             hit;
   logic [wsht_pkg::NUMBER_BITS-1:0] window_number;

   modport source (output valid, hit, window_number, input ready);
   modport sink (input valid, hit, window_number, output ready);
endinterface

>>> rtl/core/wsht_cell.sv
// ----------------------------------------------------------------------------
// Window stack hit test cell
// One stack slot: stores a window, tests a point, takes part in the shift.
// ----------------------------------------------------------------------------
module wsht_cell #(
   parameter int MAX_WINDOWS = wsht_pkg::DEF_MAX_WINDOWS,
   parameter int COORD_BITS  = wsht_pkg::DEF_COORD_BITS,
   parameter int INDEX       = 0,
   localparam int CNT_BITS   = $clog2(MAX_WINDOWS + 1),
   localparam int ENTRY_BITS = 4 * COORD_BITS + CNT_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wsht_pkg::ctrl_type    ctrl,
   input  logic [CNT_BITS-1:0]   count,
   input  logic [COORD_BITS-1:0] pt_x,
   input  logic [COORD_BITS-1:0] pt_y,
   input  logic [ENTRY_BITS-1:0] load_entry,
   input  logic [ENTRY_BITS-1:0] up_entry,
   input  logic [ENTRY_BITS-1:0] chosen_entry,
   input  logic                  above_in,
   output logic                  above_out,
   output logic [ENTRY_BITS-1:0] entry,
   output logic [ENTRY_BITS-1:0] sel_entry
);

   localparam logic [CNT_BITS-1:0] MY_INDEX = CNT_BITS'(INDEX);
   localparam logic [CNT_BITS-1:0] MY_NEXT  = CNT_BITS'(INDEX + 1);

   logic [ENTRY_BITS-1:0] entry_ff, entry_in;
   logic                  match_ff, match_in;
   logic                  above_ff, above_in_r;
   logic [COORD_BITS-1:0] xl, yl, xh, yh;
   logic                  occupied;
   logic                  inside_pt;
   logic                  sel;

   assign xl = entry_ff[CNT_BITS + 3*COORD_BITS +: COORD_BITS];
   assign yl = entry_ff[CNT_BITS + 2*COORD_BITS +: COORD_BITS];
   assign xh = entry_ff[CNT_BITS + COORD_BITS +: COORD_BITS];
   assign yh = entry_ff[CNT_BITS +: COORD_BITS];

   assign occupied  = count > MY_INDEX;
   assign inside_pt = (pt_x >= xl) && (pt_x <= xh) && (pt_y >= yl) && (pt_y <= yh);
   assign sel       = match_ff & ~above_in;
   assign above_out = match_ff | above_in;
   assign sel_entry = sel ? entry_ff : '0;
   assign entry     = entry_ff;

   always_comb begin
      entry_in   = entry_ff;
      match_in   = match_ff;
      above_in_r = above_ff;
      if (ctrl.load && count == MY_INDEX) begin
         entry_in = load_entry;
      end
      if (ctrl.compare) begin
         match_in = occupied & inside_pt;
      end
      if (ctrl.select) begin
         above_in_r = above_in;
      end
      if (ctrl.move && !above_ff) begin
         if (MY_NEXT == count) begin
            entry_in = chosen_entry;
         end else if (MY_NEXT < count) begin
            entry_in = up_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         match_ff <= 1'b0;
         above_ff <= 1'b0;
      end else begin
         match_ff <= match_in;
         above_ff <= above_in_r;
      end
   end

endmodule

>>> rtl/core/window_stack_hit_test.sv
// Window stack hit test, chain of per-window cells.
// Load beat: accepted while idle, written into the slot above the top or dropped when full; no response.
// Click beat: point test on the accepting edge, topmost-hit select and hit flag registered in
//   ST_SELECT, response register loaded with the shift to top in ST_MOVE; no new request is
//   taken until the click is through, and a full response register holds the shift step.
// Synchronous active-high reset empties the stack; slot contents are not cleared.
// ----------------------------------------------------------------------------
// Window stack hit test
// Z-ordered window stack with inclusive hit test and move to top.
// ----------------------------------------------------------------------------
module window_stack_hit_test #(
   parameter int MAX_WINDOWS = wsht_pkg::DEF_MAX_WINDOWS,
   parameter int COORD_BITS  = wsht_pkg::DEF_COORD_BITS
) (
   input logic              clock,
   input logic              reset,
   wsht_req_if.sink         req_chan,
   wsht_rsp_if.source       rsp_chan
);

   localparam int CNT_BITS   = $clog2(MAX_WINDOWS + 1);
   localparam int ENTRY_BITS = 4 * COORD_BITS + CNT_BITS;
   localparam int NB         = wsht_pkg::NUMBER_BITS;
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(MAX_WINDOWS);

   wsht_pkg::state_type   state_ff, state_in;
   wsht_pkg::ctrl_type    ctrl;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [ENTRY_BITS-1:0] chosen_ff, chosen_in;
   logic                  hit_ff, hit_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [NB-1:0]         rsp_num_ff, rsp_num_in;

   logic                  accept;
   logic                  go;
   logic [COORD_BITS-1:0] xa, ya, xb, yb;
   logic [ENTRY_BITS-1:0] load_entry;
   logic [ENTRY_BITS-1:0] chosen;
   logic [CNT_BITS+NB-1:0] num_ext;

   logic [ENTRY_BITS-1:0] cell_entry [MAX_WINDOWS];
   logic [ENTRY_BITS-1:0] cell_sel   [MAX_WINDOWS];
   logic                  above      [MAX_WINDOWS+1];

   assign xa = req_chan.corner_x_a;
   assign ya = req_chan.corner_y_a;
   assign xb = req_chan.corner_x_b;
   assign yb = req_chan.corner_y_b;

   assign load_entry = {(xa < xb) ? xa : xb, (ya < yb) ? ya : yb,
                        (xa < xb) ? xb : xa, (ya < yb) ? yb : ya,
                        count_ff + CNT_BITS'(1)};

   assign req_chan.ready = (state_ff == wsht_pkg::ST_IDLE);
   assign accept         = req_chan.valid & req_chan.ready;
   assign go             = ~rsp_valid_ff | rsp_chan.ready;

   assign above[MAX_WINDOWS] = 1'b0;

   for (genvar i = 0; i < MAX_WINDOWS; i++) begin : g_cell
      logic [ENTRY_BITS-1:0] up_entry;
      if (i == MAX_WINDOWS - 1) begin : g_top
         assign up_entry = chosen_ff;
      end else begin : g_mid
         assign up_entry = cell_entry[i+1];
      end
      wsht_cell #(
         .MAX_WINDOWS (MAX_WINDOWS),
         .COORD_BITS  (COORD_BITS),
         .INDEX       (i)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (ctrl),
         .count        (count_ff),
         .pt_x         (xa),
         .pt_y         (ya),
         .load_entry   (load_entry),
         .up_entry     (up_entry),
         .chosen_entry (chosen_ff),
         .above_in     (above[i+1]),
         .above_out    (above[i]),
         .entry        (cell_entry[i]),
         .sel_entry    (cell_sel[i])
      );
   end

   always_comb begin
      chosen = '0;
      for (int i = 0; i < MAX_WINDOWS; i++) begin
         chosen = chosen | cell_sel[i];
      end
   end

   assign num_ext = {NB'(0), chosen_ff[CNT_BITS-1:0]};

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      count_in     = count_ff;
      chosen_in    = chosen_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_num_in   = rsp_num_ff;
      unique case (state_ff)
         wsht_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_chan.mode == wsht_pkg::MODE_CLICK) begin
                  ctrl.compare = 1'b1;
                  state_in     = wsht_pkg::ST_SELECT;
               end else if (count_ff < FULL_COUNT) begin
                  ctrl.load = 1'b1;
                  count_in  = count_ff + CNT_BITS'(1);
               end
            end
         end
         wsht_pkg::ST_SELECT: begin
            ctrl.select = 1'b1;
            chosen_in   = chosen;
            hit_in      = above[0];
            state_in    = wsht_pkg::ST_MOVE;
         end
         wsht_pkg::ST_MOVE: begin
            if (go) begin
               ctrl.move    = hit_ff;
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_num_in   = hit_ff ? num_ext[NB-1:0] : '0;
               state_in     = wsht_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wsht_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      chosen_ff  <= chosen_in;
      rsp_hit_ff <= rsp_hit_in;
      rsp_num_ff <= rsp_num_in;
      if (reset) begin
         state_ff     <= wsht_pkg::ST_IDLE;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.hit           = rsp_hit_ff;
   assign rsp_chan.window_number = rsp_num_ff;

endmodule

>>> rtl/core/wsht_checker.sv
// ----------------------------------------------------------------------------
// Window stack hit test checker
// Port-level checks on response timing and contents.
// ----------------------------------------------------------------------------
`include "window_stack_hit_test_defines.svh"

module wsht_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_hit,
   input logic [wsht_pkg::NUMBER_BITS-1:0] rsp_window_number
);

   `WSHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hit) && $stable(rsp_window_number), "response beat dropped or changed while stalled")
   `WSHT_ASSERT_NOW(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_window_number == '0, "miss carries a window number")
   `WSHT_ASSERT_NEXT(a_no_instant_rsp, clock, reset, req_valid && req_ready, !$rose(rsp_valid), "response raised straight after a request beat")
   `WSHT_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid, "response pending after reset")

endmodule

bind window_stack_hit_test wsht_checker u_wsht_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_window_number (rsp_chan.window_number)
);
